// File: rtl/core/indexed_sequence_store_core_defines.svh
// Assertion macros for the indexed sequence store core.
// Included by the top level; relies on aclk and aresetn being in scope.
`ifndef INDEXED_SEQUENCE_STORE_CORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define ISS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("indexed_sequence_store_core: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define ISS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("indexed_sequence_store_core: next-cycle check failed");
`else
`define ISS_ASSERT_SAME(label, ante, cons)
`define ISS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/iss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the indexed sequence store core.
// No dependencies; imported by the top level, iss_mem and the testbench.
package iss_pkg;

    localparam int unsigned DEPTH_DEFAULT      = 256;
    localparam int unsigned WORD_WIDTH_DEFAULT = 32;

    // Fixed field widths of the request and result.
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned POS_W    = 9;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 9;

    localparam int unsigned S_TDATA_W = ((POS_W + DATA_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W = ((DATA_W + COUNT_W + 1 + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_DRAIN,
        S_FINAL,
        S_DONE
    } state_t;

endpackage

// File: rtl/core/iss_mem.sv
`timescale 1ns / 1ps
// Single-port-write, single-port-read synchronous memory for the store.
// Read data is registered and appears in the cycle after the read enable; sizes default from iss_pkg.
module iss_mem
    import iss_pkg::*;
#(
    parameter int unsigned DEPTH      = DEPTH_DEFAULT,
    parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [WORD_WIDTH-1:0]        wdata,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [WORD_WIDTH-1:0]        rdata
);

    logic [WORD_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/indexed_sequence_store_core.sv
`timescale 1ns / 1ps
// Indexed sequence store: read, insert or remove a word at a position.
// Steps: a read passes DRAIN, DONE; insert shifts n words, then DRAIN, FINAL, DONE (FINAL,
// DONE at the end); remove shifts n words, then DRAIN, DONE, where n is the number of words
// moved (count - position, or count - position - 1). One request at a time; the shift moves
// one word per cycle, limited by the single write port of the store memory.
// Reset (aresetn low, synchronous) empties the sequence; memory contents are not cleared.
`include "indexed_sequence_store_core_defines.svh"

module indexed_sequence_store_core
    import iss_pkg::*;
#(
    parameter int unsigned DEPTH      = DEPTH_DEFAULT,
    parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // position [8:0], value [40:9], zero pad
    input  logic [MODE_W-1:0]     s_tuser,  // mode [1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // data_out [31:0], count_out [40:32],
                                            // is_empty [41], zero pad
    output logic [STATUS_W-1:0]   m_tuser   // status [1:0]
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned LW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int unsigned DW = (WORD_WIDTH > DATA_W) ? WORD_WIDTH : DATA_W;

    // Request fields
    logic [POS_W-1:0]      s_pos;
    logic [DATA_W-1:0]     s_value;
    logic [MODE_W-1:0]     s_mode;
    logic [LW-1:0]         pos_ext;
    logic [LW-1:0]         cnt_ext;
    logic [DW-1:0]         val_ext;
    logic [AW-1:0]         pos_addr;
    logic [CW-1:0]         cnt_m1;
    logic                  pos_lt_cnt;
    logic                  pos_le_cnt;
    logic                  store_full;

    // Memory ports
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [WORD_WIDTH-1:0] mem_q;
    logic [DW-1:0]         mem_q_ext;

    // Control and datapath registers
    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  op_insert_reg, op_insert_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [WORD_WIDTH-1:0] val_reg, val_next;
    logic [AW-1:0]         rd_idx_reg, rd_idx_next;
    logic [AW-1:0]         last_idx_reg, last_idx_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         wr_addr_reg, wr_addr_next;
    logic                  cap_reg, cap_next;
    logic [DATA_W-1:0]     res_data_reg, res_data_next;
    status_t               res_status_reg, res_status_next;
    logic [CW-1:0]         res_count_reg, res_count_next;

    // Output register
    logic                  m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]     m_data_reg, m_data_next;
    status_t               m_status_reg, m_status_next;
    logic [CW-1:0]         m_count_reg, m_count_next;
    logic                  m_empty_reg, m_empty_next;
    logic [LW-1:0]         m_count_ext;

    assign s_pos      = s_tdata[POS_W-1:0];
    assign s_value    = s_tdata[POS_W+DATA_W-1:POS_W];
    assign s_mode     = s_tuser;
    assign pos_ext    = LW'(s_pos);
    assign cnt_ext    = LW'(count_reg);
    assign val_ext    = DW'(s_value);
    assign pos_addr   = pos_ext[AW-1:0];
    assign cnt_m1     = count_reg - CW'(1);
    assign pos_lt_cnt = (pos_ext < cnt_ext);
    assign pos_le_cnt = (pos_ext <= cnt_ext);
    assign store_full = (count_reg == CW'(DEPTH));
    assign mem_q_ext  = DW'(mem_q);

    iss_mem #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_mem (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        op_insert_next  = op_insert_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        rd_idx_next     = rd_idx_reg;
        last_idx_next   = last_idx_reg;
        pend_next       = 1'b0;
        wr_addr_next    = wr_addr_reg;
        cap_next        = 1'b0;
        res_data_next   = cap_reg ? mem_q_ext[DATA_W-1:0] : res_data_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;
        m_empty_next    = m_empty_reg;
        s_tready        = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = rd_idx_reg;
        // A word read in the previous shift cycle is written back to its new place.
        mem_we          = pend_reg;
        mem_waddr       = wr_addr_reg;
        mem_wdata       = mem_q;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    pos_next        = pos_addr;
                    val_next        = val_ext[WORD_WIDTH-1:0];
                    res_data_next   = '0;
                    res_count_next  = count_reg;
                    res_status_next = ST_RANGE;
                    op_insert_next  = 1'b0;
                    state_next      = S_DONE;
                    unique case (s_mode)
                        MODE_READ: begin
                            if (pos_lt_cnt) begin
                                mem_re          = 1'b1;
                                mem_raddr       = pos_addr;
                                cap_next        = 1'b1;
                                res_status_next = ST_OK;
                                state_next      = S_DRAIN;
                            end
                        end
                        MODE_INSERT: begin
                            if (store_full) begin
                                res_status_next = ST_FULL;
                            end else if (pos_le_cnt) begin
                                res_status_next = ST_OK;
                                res_count_next  = count_reg + CW'(1);
                                op_insert_next  = 1'b1;
                                if (pos_lt_cnt) begin
                                    rd_idx_next   = cnt_m1[AW-1:0];
                                    last_idx_next = pos_addr;
                                    state_next    = S_SHIFT;
                                end else begin
                                    state_next = S_FINAL;
                                end
                            end
                        end
                        MODE_REMOVE: begin
                            if (pos_lt_cnt) begin
                                // The first read fetches the removed word itself.
                                mem_re          = 1'b1;
                                mem_raddr       = pos_addr;
                                cap_next        = 1'b1;
                                res_status_next = ST_OK;
                                res_count_next  = cnt_m1;
                                if ((pos_ext + LW'(1)) < cnt_ext) begin
                                    rd_idx_next   = pos_addr + AW'(1);
                                    last_idx_next = cnt_m1[AW-1:0];
                                    state_next    = S_SHIFT;
                                end else begin
                                    state_next = S_DRAIN;
                                end
                            end
                        end
                        default: begin
                            res_status_next = ST_RANGE;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // Reads and writes of neighbouring shift steps never hit the same entry.
                mem_re    = 1'b1;
                mem_raddr = rd_idx_reg;
                pend_next = 1'b1;
                if (op_insert_reg) begin
                    wr_addr_next = rd_idx_reg + AW'(1);
                    rd_idx_next  = rd_idx_reg - AW'(1);
                end else begin
                    wr_addr_next = rd_idx_reg - AW'(1);
                    rd_idx_next  = rd_idx_reg + AW'(1);
                end
                if (rd_idx_reg == last_idx_reg) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = op_insert_reg ? S_FINAL : S_DONE;
            end
            S_FINAL: begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = res_data_reg;
                    m_status_next = res_status_reg;
                    m_count_next  = res_count_reg;
                    m_empty_next  = (res_count_reg == '0);
                    count_next    = res_count_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            cap_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_insert_reg  <= op_insert_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        rd_idx_reg     <= rd_idx_next;
        last_idx_reg   <= last_idx_next;
        wr_addr_reg    <= wr_addr_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        m_data_reg     <= m_data_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
        m_empty_reg    <= m_empty_next;
    end

    assign m_count_ext = LW'(m_count_reg);
    assign m_tvalid    = m_valid_reg;
    assign m_tuser     = m_status_reg;
    assign m_tdata     = M_TDATA_W'({m_empty_reg, m_count_ext[COUNT_W-1:0], m_data_reg});

    `ISS_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `ISS_ASSERT_SAME(a_no_write_idle, state_reg == S_IDLE, !mem_we)
    `ISS_ASSERT_NEXT(a_count_hold, state_reg != S_DONE, $stable(count_reg))

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_sequence_store_core: directed table, then random requests.
// Depends on iss_pkg and the core RTL; predicts untyped results from its own sequence copy.

module tb;
    import iss_pkg::*;

    localparam int unsigned DEPTH        = DEPTH_DEFAULT;
    localparam int unsigned N_RANDOM     = 450;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned SETTLE_TICKS = DEPTH + 16;

    // The one mode code that names no operation.
    localparam logic [MODE_W-1:0] MODE_UNDEFINED = 2'd3;

    typedef struct {
        logic [DATA_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                empty;
    } result_t;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        bit                typed;
        result_t           res;
    } dir_row_t;

    typedef enum {FILL_UP, MIXED, DRAIN_DOWN} regime_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [MODE_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // Shadow copy of the sequence.
    logic [DATA_W-1:0] seq_words [DEPTH];
    int unsigned       seq_count = 0;

    result_t     pending_results [$];
    dir_row_t    dir_rows [$];
    int unsigned error_count = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          pressure_on = 1'b0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned quiet_cycles = 0;

    indexed_sequence_store_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    function automatic result_t apply_request(input logic [MODE_W-1:0] mode,
                                              input logic [POS_W-1:0]  pos,
                                              input logic [DATA_W-1:0] val);
        result_t     r;
        int unsigned k;
        int unsigned p;
        r.data   = '0;
        r.status = ST_RANGE;
        p        = pos;
        case (mode)
            MODE_READ: begin
                if (p < seq_count) begin
                    r.data   = seq_words[p];
                    r.status = ST_OK;
                end
            end
            MODE_INSERT: begin
                // A full store is refused before the position is looked at.
                if (seq_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (p <= seq_count) begin
                    for (k = seq_count; k > p; k--)
                        seq_words[k] = seq_words[k-1];
                    seq_words[p] = val;
                    seq_count++;
                    r.status = ST_OK;
                end
            end
            MODE_REMOVE: begin
                if (p < seq_count) begin
                    r.data = seq_words[p];
                    for (k = p + 1; k < seq_count; k++)
                        seq_words[k-1] = seq_words[k];
                    seq_count--;
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        r.count = seq_count[COUNT_W-1:0];
        r.empty = (seq_count == 0);
        return r;
    endfunction

    task automatic add_row(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] val, input bit typed,
                           input logic [DATA_W-1:0] data, input logic [STATUS_W-1:0] status,
                           input logic [COUNT_W-1:0] count, input logic empty);
        dir_row_t row;
        row.mode       = mode;
        row.pos        = pos;
        row.val        = val;
        row.typed      = typed;
        row.res.data   = data;
        row.res.status = status;
        row.res.count  = count;
        row.res.empty  = empty;
        dir_rows.push_back(row);
    endtask

    // Offers one request, holds it until accepted, then records its expected result.
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val, input bit typed,
                                input result_t typed_res);
        result_t r;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - POS_W - DATA_W){1'b0}}, val, pos};
        s_tuser  <= mode;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        r = apply_request(mode, pos, val);
        if (typed)
            pending_results.push_back(typed_res);
        else
            pending_results.push_back(r);
    endtask

    // Receiver: random stalls, plus one long hold-off so that the core backs up.
    always @(posedge aclk) begin
        if (pressure_on && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request outstanding: data %h status %0d",
                         $time, m_tdata[DATA_W-1:0], m_tuser);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_tdata[DATA_W-1:0] !== exp_res.data) begin
                    $display("%0t: data_out expected %h got %h",
                             $time, exp_res.data, m_tdata[DATA_W-1:0]);
                    error_count++;
                end
                if (m_tuser !== exp_res.status) begin
                    $display("%0t: status expected %0d got %0d", $time, exp_res.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[DATA_W+COUNT_W-1:DATA_W] !== exp_res.count) begin
                    $display("%0t: count_out expected %0d got %0d",
                             $time, exp_res.count, m_tdata[DATA_W+COUNT_W-1:DATA_W]);
                    error_count++;
                end
                if (m_tdata[DATA_W+COUNT_W] !== exp_res.empty) begin
                    $display("%0t: is_empty expected %b got %b",
                             $time, exp_res.empty, m_tdata[DATA_W+COUNT_W]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        int unsigned       idx;
        int unsigned       roll;
        int unsigned       w_ins;
        int unsigned       w_rd;
        int unsigned       w_rm;
        int unsigned       full_hits;
        int unsigned       regime_items;
        regime_t           regime;
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        result_t           none;

        none.data   = '0;
        none.status = ST_OK;
        none.count  = '0;
        none.empty  = 1'b0;

        // Empty sequence, bad positions, undefined mode, then a few inserts and removes.
        add_row(MODE_READ,   9'd0,   32'h0000_0000, 1, 32'h0, ST_RANGE, 9'd0, 1'b1);
        add_row(MODE_REMOVE, 9'd0,   32'h0000_0000, 1, 32'h0, ST_RANGE, 9'd0, 1'b1);
        add_row(MODE_INSERT, 9'd1,   32'h0000_0005, 1, 32'h0, ST_RANGE, 9'd0, 1'b1);
        add_row(MODE_UNDEFINED, 9'd0, 32'h0000_0000, 1, 32'h0, ST_RANGE, 9'd0, 1'b1);
        add_row(MODE_INSERT, 9'd0,   32'hFFFF_FFFF, 1, 32'h0, ST_OK,    9'd1, 1'b0);
        add_row(MODE_READ,   9'd0,   32'h0000_0000, 1, 32'hFFFF_FFFF, ST_OK, 9'd1, 1'b0);
        add_row(MODE_INSERT, 9'd1,   32'h0000_0000, 1, 32'h0, ST_OK,    9'd2, 1'b0);
        add_row(MODE_INSERT, 9'd0,   32'h1234_5678, 1, 32'h0, ST_OK,    9'd3, 1'b0);
        add_row(MODE_READ,   9'd2,   32'hFFFF_FFFF, 1, 32'h0, ST_OK,    9'd3, 1'b0);
        add_row(MODE_READ,   9'd3,   32'h0000_0000, 1, 32'h0, ST_RANGE, 9'd3, 1'b0);
        add_row(MODE_INSERT, 9'd4,   32'h0000_0001, 1, 32'h0, ST_RANGE, 9'd3, 1'b0);
        add_row(MODE_INSERT, 9'd511, 32'hA5A5_5A5A, 1, 32'h0, ST_RANGE, 9'd3, 1'b0);
        add_row(MODE_READ,   9'd511, 32'h0000_0000, 1, 32'h0, ST_RANGE, 9'd3, 1'b0);
        add_row(MODE_REMOVE, 9'd256, 32'h0000_0000, 1, 32'h0, ST_RANGE, 9'd3, 1'b0);
        add_row(MODE_UNDEFINED, 9'd1, 32'hFFFF_FFFF, 1, 32'h0, ST_RANGE, 9'd3, 1'b0);
        add_row(MODE_INSERT, 9'd3,   32'h5A5A_A5A5, 0, 32'h0, ST_OK,    9'd0, 1'b0);
        add_row(MODE_INSERT, 9'd1,   32'h8000_0001, 0, 32'h0, ST_OK,    9'd0, 1'b0);
        add_row(MODE_READ,   9'd1,   32'h0000_0000, 0, 32'h0, ST_OK,    9'd0, 1'b0);
        add_row(MODE_REMOVE, 9'd2,   32'h0000_0000, 0, 32'h0, ST_OK,    9'd0, 1'b0);
        add_row(MODE_REMOVE, 9'd0,   32'h0000_0000, 0, 32'h0, ST_OK,    9'd0, 1'b0);
        add_row(MODE_REMOVE, 9'd2,   32'h0000_0000, 0, 32'h0, ST_OK,    9'd0, 1'b0);
        add_row(MODE_REMOVE, 9'd1,   32'h0000_0000, 0, 32'h0, ST_OK,    9'd0, 1'b0);
        add_row(MODE_REMOVE, 9'd0,   32'h0000_0000, 1, 32'h8000_0001, ST_OK, 9'd0, 1'b1);
        add_row(MODE_READ,   9'd0,   32'h0000_0000, 1, 32'h0, ST_RANGE, 9'd0, 1'b1);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].mode, dir_rows[i].pos, dir_rows[i].val,
                         dir_rows[i].typed, dir_rows[i].res);

        // Random part: fill the sequence up to full, mix for a while, drain, and mix again.
        pressure_on  = 1'b1;
        regime       = FILL_UP;
        full_hits    = 0;
        regime_items = 0;
        for (idx = 0; idx < N_RANDOM; idx++) begin
            case (idx * 4 / N_RANDOM)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin sender_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            case (regime)
                FILL_UP: begin w_ins = 88; w_rd = 5;  w_rm = 3;  end
                MIXED:   begin w_ins = 30; w_rd = 35; w_rm = 30; end
                default: begin w_ins = 4;  w_rd = 6;  w_rm = 85; end
            endcase
            roll = $urandom_range(99);
            val  = $urandom();
            if (roll < w_ins) begin
                mode = MODE_INSERT;
                pos  = POS_W'($urandom_range(seq_count, 0));
            end else if (roll < w_ins + w_rd) begin
                mode = MODE_READ;
                pos  = (seq_count == 0) ? '0 : POS_W'($urandom_range(seq_count - 1, 0));
            end else if (roll < w_ins + w_rd + w_rm) begin
                mode = MODE_REMOVE;
                pos  = (seq_count == 0) ? '0 : POS_W'($urandom_range(seq_count - 1, 0));
            end else begin
                // Noise: any mode, including the undefined one, at any position.
                mode = MODE_W'($urandom_range(3, 0));
                pos  = POS_W'($urandom_range(511, 0));
            end
            send_request(mode, pos, val, 1'b0, none);

            case (regime)
                FILL_UP: begin
                    if (seq_count == DEPTH)
                        full_hits++;
                    if (full_hits >= 12) begin
                        regime       = MIXED;
                        regime_items = 0;
                    end
                end
                MIXED: begin
                    regime_items++;
                    if (regime_items >= 60)
                        regime = DRAIN_DOWN;
                end
                default: begin
                    if (seq_count == 0) begin
                        regime       = MIXED;
                        regime_items = 0;
                    end
                end
            endcase
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);

        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
